[src/cascaded_biquad_iir_filter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion helpers for the cascaded biquad filter.
// Each check is clocked on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH

// same-cycle implication
`define CBQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbq: same-cycle check failed");

// next-cycle implication
`define CBQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbq: next-cycle check failed");

`endif

[src/cbq_pkg.sv]
// ----------------------------------------------------------------------------
// cbq_pkg
// Sizes, codes, shared types and the Q.20 round/saturate helper.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int MAX_CHANNELS = 8;

  localparam int SEC_IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CH_IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W     = $clog2(MAX_SECTIONS + 1);

  localparam int COEFS_PER_SEC = 5;
  localparam int SLOT_A1 = 0;
  localparam int SLOT_A2 = 1;
  localparam int SLOT_B0 = 2;
  localparam int SLOT_B1 = 3;
  localparam int SLOT_B2 = 4;

  localparam logic [1:0] CMD_FILTER = 2'd0;
  localparam logic [1:0] CMD_COEF   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int HIST_W   = 32;
  localparam int PROD_W   = HIST_W + COEF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_W   = 20;
  localparam int SHR_W    = ACC_W - FRAC_W;

  localparam longint Q20_MAX = 64'sd2147483647;
  localparam longint Q20_MIN = -64'sd2147483648;
  localparam longint Q20_HALF = 64'sd524288;

  typedef struct packed {
    logic                valid;
    logic [CH_IDX_W-1:0] ch;
    logic [HIST_W-1:0]   x;
    logic                sat;
  } cbq_tok_t;

  typedef struct packed {
    logic              en;
    logic [5:0]        index;
    logic [COEF_W-1:0] value;
  } cbq_coef_wr_t;

  typedef struct packed {
    logic [HIST_W-1:0] value;
    logic              clip;
  } cbq_sat_t;

  typedef struct packed {
    logic [2:0]          ch;
    logic [SAMPLE_W-1:0] sample;
    logic                sat;
  } cbq_res_t;

  // Q.40 sum to Q.20, round half up, clip to 32 bits
  function automatic cbq_sat_t round_sat20(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [SHR_W-1:0] s;
    cbq_sat_t r;
    t = acc + ACC_W'(Q20_HALF);
    s = t[ACC_W-1:FRAC_W];
    if (s > SHR_W'(Q20_MAX)) begin
      r.value = 32'h7fff_ffff;
      r.clip  = 1'b1;
    end else if (s < SHR_W'(Q20_MIN)) begin
      r.value = 32'h8000_0000;
      r.clip  = 1'b1;
    end else begin
      r.value = s[HIST_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

[src/cbq_ram.sv]
// ----------------------------------------------------------------------------
// cbq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/cbq_cell.sv]
// ----------------------------------------------------------------------------
// cbq_cell
// One biquad section: its five coefficients, per-channel history and a
// five-stage multiply/round pipe that hands its y to the next cell.
// ----------------------------------------------------------------------------
module cbq_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cbq_pkg::SEC_IDX_W-1:0]  sec_id,
  input  cbq_pkg::cbq_coef_wr_t          coef_wr,
  input  logic                           hist_clr,
  input  cbq_pkg::cbq_tok_t              tok_in,
  output cbq_pkg::cbq_tok_t              tok_out
);
  import cbq_pkg::*;

  logic signed [COEF_W-1:0] coef [COEFS_PER_SEC];

  // history entry per channel: {w2, w1}; valid flag clear reads as zero
  logic [MAX_CHANNELS-1:0] hvalid;
  logic                    hist_we;
  logic [CH_IDX_W-1:0]     hist_waddr;
  logic [2*HIST_W-1:0]     hist_wdata;
  logic [2*HIST_W-1:0]     hist_rdata;

  logic                     v0, v1, v2, v3;
  logic [CH_IDX_W-1:0]      ch0, ch1, ch2, ch3;
  logic                     fl0, fl1, fl2, fl3;
  logic                     hv0;
  logic signed [HIST_W-1:0] x0, x1;
  logic signed [HIST_W-1:0] w1c, w2c;
  logic signed [HIST_W-1:0] w1_1, w2_1, w1_2, w_2;
  logic signed [PROD_W-1:0] pa1, pa2, pb1, pb2, pb0;
  logic [PROD_W:0]          sb;
  logic signed [ACC_W-1:0]  acc_w, acc_y;
  cbq_sat_t                 rw, ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < COEFS_PER_SEC; k++) begin
        coef[k] <= '0;
      end
    end else begin
      for (int k = 0; k < COEFS_PER_SEC; k++) begin
        if (coef_wr.en && (32'(coef_wr.index) ==
            32'(sec_id) * 32'(COEFS_PER_SEC) + 32'(k))) begin
          coef[k] <= coef_wr.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else if (hist_clr) begin
      hvalid <= '0;
    end else if (hist_we) begin
      hvalid[hist_waddr] <= 1'b1;
    end
  end

  assign hist_we    = v2;
  assign hist_waddr = ch2;
  assign hist_wdata = {w1_2, w_2};

  cbq_ram #(
    .WIDTH (2 * HIST_W),
    .DEPTH (MAX_CHANNELS)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (tok_in.ch),
    .rdata (hist_rdata)
  );

  always_comb begin
    w1c   = hv0 ? $signed(hist_rdata[HIST_W-1:0]) : '0;
    w2c   = hv0 ? $signed(hist_rdata[2*HIST_W-1:HIST_W]) : '0;
    acc_w = $signed({{(ACC_W-HIST_W-FRAC_W){x1[HIST_W-1]}}, x1, {FRAC_W{1'b0}}})
          - $signed({{(ACC_W-PROD_W){pa1[PROD_W-1]}}, pa1})
          - $signed({{(ACC_W-PROD_W){pa2[PROD_W-1]}}, pa2});
    rw    = round_sat20(acc_w);
    acc_y = $signed({{(ACC_W-PROD_W){pb0[PROD_W-1]}}, pb0})
          + $signed({{(ACC_W-PROD_W-1){sb[PROD_W]}}, sb});
    ry    = round_sat20(acc_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0            <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      v0            <= tok_in.valid;
      v1            <= v0;
      v2            <= v1;
      v3            <= v2;
      tok_out.valid <= v3;
    end
    // stage 0: capture request, history read in flight
    ch0 <= tok_in.ch;
    x0  <= tok_in.x;
    fl0 <= tok_in.sat;
    hv0 <= hvalid[tok_in.ch];
    // stage 1: feedback products
    ch1  <= ch0;
    x1   <= x0;
    fl1  <= fl0;
    w1_1 <= w1c;
    w2_1 <= w2c;
    pa1  <= w1c * coef[SLOT_A1];
    pa2  <= w2c * coef[SLOT_A2];
    // stage 2: new w, feedforward products on old history
    ch2  <= ch1;
    fl2  <= fl1 | rw.clip;
    w_2  <= rw.value;
    w1_2 <= w1_1;
    pb1  <= w1_1 * coef[SLOT_B1];
    pb2  <= w2_1 * coef[SLOT_B2];
    // stage 3: b0*w and partial sum
    ch3 <= ch2;
    fl3 <= fl2;
    pb0 <= w_2 * coef[SLOT_B0];
    sb  <= {pb1[PROD_W-1], pb1} + {pb2[PROD_W-1], pb2};
    // output: section y
    tok_out.ch  <= ch3;
    tok_out.x   <= ry.value;
    tok_out.sat <= fl3 | ry.clip;
  end

endmodule

[src/cascaded_biquad_iir_filter.sv]
// One filter request in flight: s_tready is low from an accepted filter request
//   until its result leaves the section row, and while a result waits in the skid entry.
//   A sample passes the five-stage multiply/round pipe of each of the N sections in
//   use (num_sections clipped to the section count); with N zero it is bypassed.
// Coefficient and clear requests are accepted under the same s_tready. Synchronous rst
//   zeroes all coefficients and history flags and sets num_sections to 1.
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter
// Multichannel direct form II biquad cascade, a row of section cells.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_iir_filter_assert.svh"

module cascaded_biquad_iir_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // channel[2:0], sample_in[15:0], coef_index[5:0],
                                 // coef_value[23:0], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // channel_out[2:0], sample_out[15:0], zero pad
  output logic [0:0]  m_tuser,   // saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data   // num_sections
);
  import cbq_pkg::*;

  logic [3:0]          num_sections;
  logic [CNT_W-1:0]    ns_eff;
  logic [SEC_IDX_W-1:0] sel;

  logic                s_accept;
  logic [1:0]          cmd;
  logic [2:0]          channel;
  logic [SAMPLE_W-1:0] sample_in;
  logic                chan_ok;
  logic                start_item;
  logic                chain_start;

  cbq_coef_wr_t        coef_wr;
  logic                hist_clr;
  cbq_tok_t            tok_in  [MAX_SECTIONS];
  cbq_tok_t            cell_out [MAX_SECTIONS];

  logic                busy;
  logic                byp_valid;
  logic [2:0]          byp_ch;
  logic [SAMPLE_W-1:0] byp_sample;

  cbq_tok_t            sel_tok;
  logic                chain_valid;
  logic                res_valid;
  logic signed [HIST_W:0]   rnd;
  logic signed [HIST_W-5:0] q15;
  cbq_res_t            res;
  cbq_res_t            out_q;
  cbq_res_t            pend_q;
  logic                pend_valid;
  logic                take;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sections <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      num_sections <= cfg_data;
    end
  end

  assign ns_eff = (32'(num_sections) > 32'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                          : CNT_W'(num_sections);
  assign sel    = (ns_eff == '0) ? '0 : SEC_IDX_W'(ns_eff - CNT_W'(1));

  // input decode
  assign s_tready = !busy && !pend_valid;
  assign s_accept = s_tvalid && s_tready;
  assign cmd       = s_tuser;
  assign channel   = s_tdata[2:0];
  assign sample_in = s_tdata[18:3];
  assign chan_ok     = 32'(channel) < 32'(MAX_CHANNELS);
  assign start_item  = s_accept && (cmd == CMD_FILTER) && chan_ok;
  assign chain_start = start_item && (ns_eff != '0);

  always_comb begin
    coef_wr.en    = s_accept && (cmd == CMD_COEF);
    coef_wr.index = s_tdata[24:19];
    coef_wr.value = s_tdata[48:25];
    hist_clr      = s_accept && (cmd == CMD_CLEAR);
  end

  // cell row; a cell past the sections in use never sees a request
  always_comb begin
    tok_in[0].valid = chain_start;
    tok_in[0].ch    = CH_IDX_W'(channel);
    tok_in[0].x     = {{(HIST_W-SAMPLE_W-5){sample_in[SAMPLE_W-1]}}, sample_in, 5'd0};
    tok_in[0].sat   = 1'b0;
    for (int i = 1; i < MAX_SECTIONS; i++) begin
      tok_in[i]       = cell_out[i-1];
      tok_in[i].valid = cell_out[i-1].valid && (CNT_W'(i) < ns_eff);
    end
  end

  for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
    cbq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .sec_id   (SEC_IDX_W'(g)),
      .coef_wr  (coef_wr),
      .hist_clr (hist_clr),
      .tok_in   (tok_in[g]),
      .tok_out  (cell_out[g])
    );
  end

  // zero-section bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= start_item && (ns_eff == '0);
    end
    byp_ch     <= channel;
    byp_sample <= sample_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (res_valid) begin
      busy <= 1'b0;
    end else if (start_item) begin
      busy <= 1'b1;
    end
  end

  // final Q12.20 to Q1.15: round half up, clip
  assign sel_tok     = cell_out[sel];
  assign chain_valid = (ns_eff != '0) && sel_tok.valid;
  assign res_valid   = chain_valid || byp_valid;

  always_comb begin
    rnd = $signed({sel_tok.x[HIST_W-1], sel_tok.x}) + 33'sd16;
    q15 = rnd[HIST_W:5];
    if (byp_valid) begin
      res.ch     = byp_ch;
      res.sample = byp_sample;
      res.sat    = 1'b0;
    end else begin
      res.ch = 3'(sel_tok.ch);
      if (q15 > 28'sd32767) begin
        res.sample = 16'h7fff;
        res.sat    = 1'b1;
      end else if (q15 < -28'sd32768) begin
        res.sample = 16'h8000;
        res.sat    = 1'b1;
      end else begin
        res.sample = q15[SAMPLE_W-1:0];
        res.sat    = sel_tok.sat;
      end
    end
  end

  // output register with one skid entry
  assign take = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      if (take) begin
        out_q      <= pend_q;
        pend_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!m_tvalid || take) begin
        out_q    <= res;
        m_tvalid <= 1'b1;
      end else begin
        pend_q     <= res;
        pend_valid <= 1'b1;
      end
    end else if (take) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'd0, out_q.sample, out_q.ch};
  assign m_tuser = out_q.sat;

  `CBQ_ASSERT_IMP(a_pend_has_out, pend_valid, m_tvalid)
  `CBQ_ASSERT_IMP(a_res_when_busy, res_valid, busy)
  `CBQ_ASSERT_IMP(a_res_no_pend, res_valid, !pend_valid)
  `CBQ_ASSERT_NXT(a_start_busy, start_item, busy)

endmodule

[tb/sv/tb_cascaded_biquad_iir_filter.sv]
// ----------------------------------------------------------------------------
// tb_cascaded_biquad_iir_filter
// Drives filter, coefficient and clear requests into the biquad cascade,
// predicts each filtered sample in fixed point and compares every output
// request field by field. Runs a short directed table, then random traffic
// under several section counts and idle/stall patterns, including one long
// output hold-off that backs the pipe up into its input.
// ----------------------------------------------------------------------------
module tb_cascaded_biquad_iir_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import cbq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int COEF_SLOTS   = MAX_SECTIONS * COEFS_PER_SEC;
  localparam int HIST_SLOTS   = MAX_CHANNELS * MAX_SECTIONS * 2;
  localparam int SETTLE       = 5 * MAX_SECTIONS + 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 133;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [1:0]         cmd;
    logic [2:0]         ch;
    logic signed [15:0] smp;
    logic [5:0]         idx;
    logic signed [23:0] val;
  } req_t;

  typedef struct {
    bit         is_cfg;
    logic [3:0] sections;
    req_t       req;
    bit         typed;
    cbq_res_t   want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  // predictor state
  logic signed [23:0] coef_mem [COEF_SLOTS];
  logic signed [31:0] hist_w [HIST_SLOTS];
  logic [3:0]         sections_used;
  cbq_res_t           filtered_q [$];
  cbq_res_t           head;

  int  errors = 0;
  int  cycles = 0;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  int  hold_left = 0;
  bit  hold_start = 1'b0;
  row_t dir_rows [$];

  cascaded_biquad_iir_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Q.40 sum to Q.20, round half up, clip to 32 bits
  function automatic longint round_q20(input longint acc, inout bit clip);
    longint t;
    t = (acc + 64'sd524288) >>> 20;
    if (t > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (t < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return t;
  endfunction

  // updates coefficient/history state; returns 1 when a sample comes out
  function automatic bit filter_step(input req_t r, output cbq_res_t res);
    longint x, acc, w, w1, w2, fin;
    int ns, h, c;
    bit clip;
    res  = '0;
    clip = 1'b0;
    if (r.cmd == CMD_COEF) begin
      if (r.idx < COEF_SLOTS) coef_mem[r.idx] = r.val;
      return 1'b0;
    end
    if (r.cmd == CMD_CLEAR) begin
      foreach (hist_w[i]) hist_w[i] = '0;
      return 1'b0;
    end
    if (r.cmd != CMD_FILTER || r.ch >= MAX_CHANNELS) return 1'b0;
    ns = (sections_used > MAX_SECTIONS) ? MAX_SECTIONS : sections_used;
    if (ns == 0) begin
      fin = longint'(r.smp);
    end else begin
      x = longint'(r.smp) * 32;
      for (int s = 0; s < ns; s++) begin
        c  = s * COEFS_PER_SEC;
        h  = (int'(r.ch) * MAX_SECTIONS + s) * 2;
        w1 = longint'(hist_w[h]);
        w2 = longint'(hist_w[h + 1]);
        acc = x * 64'sd1048576 - w1 * longint'(coef_mem[c + SLOT_A1])
              - w2 * longint'(coef_mem[c + SLOT_A2]);
        w = round_q20(acc, clip);
        acc = w * longint'(coef_mem[c + SLOT_B0]) + w1 * longint'(coef_mem[c + SLOT_B1])
              + w2 * longint'(coef_mem[c + SLOT_B2]);
        x = round_q20(acc, clip);
        hist_w[h + 1] = 32'(w1);
        hist_w[h]     = 32'(w);
      end
      fin = (x + 16) >>> 5;
      if (fin > 32767) begin
        fin  = 32767;
        clip = 1'b1;
      end
      if (fin < -32768) begin
        fin  = -32768;
        clip = 1'b1;
      end
    end
    res.ch     = r.ch;
    res.sample = 16'(fin);
    res.sat    = clip;
    return 1'b1;
  endfunction

  function automatic row_t item_row(input logic [1:0] cmd, input int ch, input int smp,
                                    input int idx, input int val);
    row_t r;
    r = '{default: '0};
    r.req.cmd = cmd;
    r.req.ch  = 3'(ch);
    r.req.smp = 16'(smp);
    r.req.idx = 6'(idx);
    r.req.val = 24'(val);
    return r;
  endfunction

  function automatic row_t known_row(input int ch, input int smp, input int want_smp,
                                     input bit want_sat);
    row_t r;
    r = item_row(CMD_FILTER, ch, smp, 0, 0);
    r.typed       = 1'b1;
    r.want.ch     = 3'(ch);
    r.want.sample = 16'(want_smp);
    r.want.sat    = want_sat;
    return r;
  endfunction

  function automatic row_t sections_row(input int n);
    row_t r;
    r = '{default: '0};
    r.is_cfg   = 1'b1;
    r.sections = 4'(n);
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int pick;
    pick  = $urandom_range(99);
    r.ch  = 3'($urandom);
    r.smp = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(8191) - 4096);
    r.idx = ($urandom_range(9) == 0) ? 6'($urandom_range(63, COEF_SLOTS))
                                     : 6'($urandom_range(COEF_SLOTS - 1));
    // mostly gentle coefficients so the cascade stays in range
    r.val = ($urandom_range(9) < 3) ? 24'($urandom) : 24'($urandom_range(1048576) - 524288);
    if (pick < 70)      r.cmd = CMD_FILTER;
    else if (pick < 92) r.cmd = CMD_COEF;
    else if (pick < 96) r.cmd = CMD_CLEAR;
    else                r.cmd = CMD_UNUSED;
    return r;
  endfunction

  task automatic push_req(input req_t r, input bit typed, input cbq_res_t want);
    cbq_res_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {7'd0, r.val, r.idx, r.smp, r.ch};
    do @(posedge clk); while (!s_tready);
    if (filter_step(r, got)) filtered_q.push_back(typed ? want : got);
  endtask

  // section count changes only once the pipe has drained
  task automatic set_sections(input logic [3:0] n);
    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sections_used = n;
  endtask

  // output side: random stall plus the long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output ch %0d sample %0d",
                                  m_tdata[2:0], $signed(m_tdata[18:3])));
      end else begin
        head = filtered_q.pop_front();
        if (m_tdata[2:0] !== head.ch)
          report_mismatch($sformatf("channel got %0d want %0d", m_tdata[2:0], head.ch));
        if (m_tdata[18:3] !== head.sample)
          report_mismatch($sformatf("ch %0d sample got %0d want %0d", head.ch,
                                    $signed(m_tdata[18:3]), $signed(head.sample)));
        if (m_tuser[0] !== head.sat)
          report_mismatch($sformatf("ch %0d saturated got %b want %b", head.ch,
                                    m_tuser[0], head.sat));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int done;
    req_t r;
    logic [3:0] phase_sections [8];
    cbq_res_t none;
    none = '0;
    phase_sections = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd2, 4'd5, 4'd4};
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (hist_w[i]) hist_w[i] = '0;
    sections_used = 4'd1;

    dir_rows = '{
      known_row(0, 32767, 0, 1'b0),            // all coefficients zero after reset
      known_row(7, -32768, 0, 1'b0),
      item_row(CMD_COEF, 0, 0, SLOT_B0, 1 << 20),   // b0 = 1.0: straight through
      known_row(1, 32767, 32767, 1'b0),
      known_row(6, -32768, -32768, 1'b0),
      item_row(CMD_COEF, 0, 0, 63, -8388608),   // index past the table
      item_row(CMD_UNUSED, 5, 1234, 9, 777),
      known_row(2, 100, 100, 1'b0),
      item_row(CMD_COEF, 0, 0, SLOT_A1, -8388608),
      item_row(CMD_FILTER, 3, 32767, 0, 0),
      item_row(CMD_FILTER, 3, 32767, 0, 0),
      item_row(CMD_FILTER, 3, -32768, 0, 0),
      item_row(CMD_COEF, 0, 0, SLOT_A2, 8388607),
      item_row(CMD_COEF, 0, 0, SLOT_B1, 8388607),
      item_row(CMD_COEF, 0, 0, SLOT_B2, -8388608),
      item_row(CMD_FILTER, 3, -32768, 0, 0),
      item_row(CMD_FILTER, 3, 32767, 0, 0),
      item_row(CMD_CLEAR, 0, 0, 0, 0),
      item_row(CMD_FILTER, 3, -1, 0, 0),
      sections_row(0),                          // no sections: sample passes as is
      known_row(4, -12345, -12345, 1'b0),
      known_row(5, 32767, 32767, 1'b0),
      sections_row(15),                         // acts as all sections
      item_row(CMD_COEF, 0, 0, COEF_SLOTS - 1, 1 << 19),
      item_row(CMD_FILTER, 7, -32768, 0, 0),
      item_row(CMD_FILTER, 0, 20000, 0, 0)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_sections(dir_rows[i].sections);
      else push_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      set_sections(phase_sections[p]);
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 74;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 74;
        end
        default: begin
          tx_idle_pct = 35;
          rx_stall_pct <= 35;
        end
      endcase
      if (p == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        r = rand_req();
        push_req(r, 1'b0, none);
        if (!(r.cmd == CMD_UNUSED || (r.cmd == CMD_COEF && r.idx >= COEF_SLOTS))) done++;
      end
    end

    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/cbq_pkg.sv
src/cbq_ram.sv
src/cbq_cell.sv
src/cascaded_biquad_iir_filter.sv
tb/sv/tb_cascaded_biquad_iir_filter.sv
